// File: hdl/tise_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tise_pkg;
  localparam int CodeBytes = 128;
  localparam int AddrW = $clog2(CodeBytes);
  localparam int PcW = 17;
  localparam int NumRegs = 16;
  localparam int InsnBytes = 4;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_REPORT  = 2'd3
  } action_e;

  localparam logic [3:0] OP_LDI = 4'h0;
  localparam logic [3:0] OP_MOV = 4'h1;
  localparam logic [3:0] OP_LDM = 4'h2;
  localparam logic [3:0] OP_STM = 4'h3;
  localparam logic [3:0] OP_CMP = 4'h4;
  localparam logic [3:0] OP_JMP = 4'h5;
  localparam logic [3:0] OP_JGT = 4'h6;
  localparam logic [3:0] OP_JLT = 4'h7;
  localparam logic [3:0] OP_JEQ = 4'h8;
  localparam logic [3:0] OP_ADD = 4'h9;
  localparam logic [3:0] OP_SUB = 4'hA;
  localparam logic [3:0] OP_AND = 4'hB;
  localparam logic [3:0] OP_OR  = 4'hC;
  localparam logic [3:0] OP_XOR = 4'hD;
  localparam logic [3:0] OP_SHL = 4'hE;
  localparam logic [3:0] OP_SHR = 4'hF;

  // controller to datapath
  typedef struct packed {
    logic       capture;  // register the input word
    logic       mem_load; // write the load byte
    logic       fetch;    // read bytes pc and pc+1
    logic       fetch_hi; // read bytes pc+2 and pc+3, latch opcode and selects
    logic       operand;  // read the load operand, latch immediate bytes
    logic       exec;     // execute fetched instruction
    logic       restart;  // clear architectural state
  } tise_cmd_t;

  typedef struct packed {
    logic       can_step; // pc below program length
    logic [1:0] action;
  } tise_sts_t;
endpackage
`default_nettype wire

// File: hdl/tise_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tise_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire tise_pkg::tise_cmd_t cmd_i,
  output tise_pkg::tise_sts_t sts_o,
  input  wire [1:0]           action_i,
  input  wire [6:0]           address_i,
  input  wire [7:0]           data_i,
  input  wire [3:0]           reg_select_i,
  input  wire                 cfg_valid_i,
  input  wire [7:0]           cfg_data_i,
  output logic [16:0]         pc_o,
  output logic                halted_o,
  output logic                flag_eq_o,
  output logic                flag_gt_o,
  output logic                flag_lt_o,
  output logic [7:0]          opcode_done_o,
  output logic                illegal_o,
  output logic [31:0]         reg_value_o,
  output logic [31:0]         op_count_o
);
  import tise_pkg::*;

  logic [7:0]  mem [CodeBytes];
  logic [31:0] regs_q [NumRegs];
  logic [31:0] cnt_q [NumRegs];
  logic [PcW-1:0] pc_q;
  logic [2:0]  flags_q; // eq, gt, lt in bits 0..2
  logic [7:0]  plen_q;
  logic [1:0]  act_q;
  logic [6:0]  addr_q;
  logic [7:0]  data_q;
  logic [3:0]  sel_q;
  logic [7:0]  op_q, rsel_q, lo_q, hi_q;
  logic [7:0]  rd0_q, rd1_q;
  logic [7:0]  opd_q;
  logic        ill_q;

  logic [AddrW-1:0] pc_a, ra0, ra1, wa;
  logic [7:0]  wd;
  logic        we;
  logic [3:0]  rx, ry;
  logic [31:0] a, b, res;
  logic        wr, jump;
  logic [15:0] imm;
  logic [PcW-1:0] next_pc;

  assign pc_a = pc_q[AddrW-1:0];
  assign rx = rsel_q[7:4];
  assign ry = rsel_q[3:0];
  assign a = regs_q[rx];
  assign b = regs_q[ry];
  assign imm = {hi_q, lo_q};

  // two read addresses a cycle: pc and pc+1, then pc+2 and pc+3, then the load operand
  always_comb begin
    ra0 = pc_a;
    ra1 = AddrW'(pc_a + AddrW'(1));
    if (cmd_i.fetch_hi) begin
      ra0 = AddrW'(pc_a + AddrW'(2));
      ra1 = AddrW'(pc_a + AddrW'(3));
    end else if (cmd_i.operand) begin
      ra0 = b[AddrW-1:0];
    end
  end

  assign we = cmd_i.mem_load || (cmd_i.exec && op_q == {4'h0, OP_STM});
  assign wa = cmd_i.mem_load ? addr_q[AddrW-1:0] : a[AddrW-1:0];
  assign wd = cmd_i.mem_load ? data_q : b[7:0];

  // memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.fetch || cmd_i.fetch_hi || cmd_i.operand) begin
      rd0_q <= mem[ra0];
      rd1_q <= mem[ra1];
    end
  end

  // latch instruction bytes in the cycle after their read
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_hi) begin
      op_q   <= rd0_q;
      rsel_q <= rd1_q;
    end
    if (cmd_i.operand) begin
      lo_q <= rd0_q;
      hi_q <= rd1_q;
    end
  end

  always_comb begin
    wr = 1'b1;
    jump = 1'b0;
    res = a;
    case (op_q[3:0])
      OP_LDI: res = {16'h0, imm};
      OP_MOV: res = b;
      OP_LDM: res = {24'h0, rd0_q};
      OP_STM: wr = 1'b0;
      OP_CMP: wr = 1'b0;
      OP_JMP: begin wr = 1'b0; jump = 1'b1; end
      OP_JGT: begin wr = 1'b0; jump = flags_q[1]; end
      OP_JLT: begin wr = 1'b0; jump = flags_q[2]; end
      OP_JEQ: begin wr = 1'b0; jump = flags_q[0]; end
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_AND: res = a & b;
      OP_OR:  res = a | b;
      OP_XOR: res = a ^ b;
      OP_SHL: res = (hi_q >= 8'd32) ? 32'h0 : (a << hi_q[4:0]);
      OP_SHR: res = (hi_q >= 8'd32) ? 32'h0 : (a >> hi_q[4:0]);
      default: wr = 1'b0;
    endcase
    if (op_q[7:4] != 4'h0) begin
      wr = 1'b0;
      jump = 1'b0;
    end
    next_pc = pc_q + PcW'(InsnBytes) + (jump ? PcW'(imm) : PcW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      flags_q <= '0;
      plen_q <= '0;
      opd_q <= '0;
      ill_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) plen_q <= cfg_data_i;
      if (cmd_i.capture) begin
        opd_q <= '0;
        ill_q <= 1'b0;
      end
      if (cmd_i.restart) begin
        pc_q <= '0;
        flags_q <= '0;
        for (int i = 0; i < NumRegs; i++) begin
          regs_q[i] <= '0;
          cnt_q[i] <= '0;
        end
      end
      if (cmd_i.exec) begin
        opd_q <= op_q;
        ill_q <= (op_q[7:4] != 4'h0);
        pc_q <= next_pc;
        if (wr) regs_q[rx] <= res;
        if (op_q[7:4] == 4'h0) begin
          cnt_q[op_q[3:0]] <= cnt_q[op_q[3:0]] + 32'd1;
          if (op_q[3:0] == OP_CMP) flags_q <= {a < b, a > b, a == b};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      addr_q <= address_i;
      data_q <= data_i;
      sel_q <= reg_select_i;
    end
  end

  assign sts_o.can_step = (pc_q < PcW'(plen_q));
  assign sts_o.action = act_q;

  assign pc_o = pc_q;
  assign halted_o = !sts_o.can_step;
  assign flag_eq_o = flags_q[0];
  assign flag_gt_o = flags_q[1];
  assign flag_lt_o = flags_q[2];
  assign opcode_done_o = opd_q;
  assign illegal_o = ill_q;
  assign reg_value_o = regs_q[sel_q];
  assign op_count_o = cnt_q[sel_q];
endmodule
`default_nettype wire

// File: hdl/tise_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tise_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tise_pkg::tise_cmd_t cmd_o,
  input  wire tise_pkg::tise_sts_t sts_i
);
  import tise_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_FETCH = 6'b000100,
    S_OPND  = 6'b001000,
    S_EXEC  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.capture = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        case (sts_i.action)
          ACT_LOAD: begin cmd_o.mem_load = 1'b1; state_d = S_OUT; end
          ACT_STEP: if (sts_i.can_step) begin
            cmd_o.fetch = 1'b1;
            state_d = S_FETCH;
          end else state_d = S_OUT;
          ACT_RESTART: begin cmd_o.restart = 1'b1; state_d = S_OUT; end
          default: state_d = S_OUT;
        endcase
      end
      S_FETCH: begin
        cmd_o.fetch_hi = 1'b1;
        state_d = S_OPND;
      end
      S_OPND: begin
        cmd_o.operand = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// File: hdl/toy_isa_step_executor.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata: action[1:0] address[8:2] data[16:9] reg_select[20:17]
// m_axis   | out       | tdata: pc, halted, eq, gt, lt, opcode_done, illegal, reg, count
// cfg      | in        | cfg_data_i: program_length
// A load, restart, report or halted step passes accept, decode and the output beat.
// An executed step passes accept, decode with the first fetch read, the second fetch read
// (two bytes each), operand read, execute, output beat; memory reads two addresses a cycle.
// One word is in flight at a time. Reset clears pc, flags, registers, counters
// and program_length; memory is not cleared. Output stalls hold the result and the input.
`timescale 1ns / 1ps
`default_nettype none
module toy_isa_step_executor (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire [23:0]   s_axis_tdata,  // action, address, data, reg_select
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // pc, halted, flag_eq, flag_gt, flag_lt, opcode_done, illegal, reg_value, op_count
  output logic [95:0]  m_axis_tdata,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire [7:0]    cfg_data_i
);
  import tise_pkg::*;

  tise_cmd_t cmd;
  tise_sts_t sts;
  logic [16:0] pc;
  logic halted, feq, fgt, flt, ill;
  logic [7:0] opd;
  logic [31:0] rv, oc;

  assign cfg_ready_o = 1'b1;

  tise_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  tise_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i(s_axis_tdata[1:0]), .address_i(s_axis_tdata[8:2]),
    .data_i(s_axis_tdata[16:9]), .reg_select_i(s_axis_tdata[20:17]),
    .cfg_valid_i, .cfg_data_i,
    .pc_o(pc), .halted_o(halted), .flag_eq_o(feq), .flag_gt_o(fgt), .flag_lt_o(flt),
    .opcode_done_o(opd), .illegal_o(ill), .reg_value_o(rv), .op_count_o(oc)
  );

  assign m_axis_tdata = {2'b00, oc, rv, ill, opd, flt, fgt, feq, halted, pc};
endmodule
`default_nettype wire

// File: hdl/tise_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tise_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire s_axis_tvalid,
  input wire s_axis_tready,
  input wire m_axis_tvalid,
  input wire m_axis_tready,
  input wire [95:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
  a_ill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[28:25] != 4'h0)
    else $error("illegal with legal op");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready stuck");
endmodule

bind toy_isa_step_executor tise_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
